// File: sv/qte_pkg.sv
// Types, widths and constants shared by the quaternion to Euler angle block.
// Holds the arctangent table and the square-root and CORDIC step functions.
// No dependencies.
package qte_pkg;

	// Matrix entries at 30 fraction bits, with head room for unnormalised input.
	localparam int MW = 35;
	// Matrix entries rounded to 15 fraction bits.
	localparam int RW = MW - 15;
	// Sum of squares for the square root, and the width of the root.
	localparam int SW = 36;
	localparam int QW = SW / 2;
	localparam int REMW = QW + 4;
	// CORDIC datapath width.
	localparam int CW = 40;

	// The four CORDIC units that run side by side.
	localparam int NUM_UNITS = 4;
	localparam int U_PITCH = 0;
	localparam int U_YAW = 1;
	localparam int U_ROLL = 2;
	localparam int U_ROLL_SING = 3;

	localparam logic signed [MW-1:0] ONE_Q30 = MW'(64'sd1073741824);
	localparam logic signed [MW-1:0] HALF_Q15 = MW'(64'sd16384);
	localparam logic [31:0] ANGLE_PI = 32'h8000_0000;
	localparam logic [31:0] ROUND_HALF = 32'h0000_8000;
	localparam logic signed [15:0] PITCH_MAX = 16'sd16384;
	localparam logic signed [15:0] PITCH_MIN = -16'sd16384;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef struct packed {
		logic signed [MW-1:0] m00;
		logic signed [MW-1:0] m01;
		logic signed [MW-1:0] m10;
		logic signed [MW-1:0] m11;
		logic signed [MW-1:0] m20;
		logic signed [MW-1:0] m21;
		logic signed [MW-1:0] m22;
	} mat_t;

	typedef struct packed {
		logic [SW-1:0] rad;
		logic [REMW-1:0] rem;
		logic [QW-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0] z;
		logic zero;
	} cordic_t;

	// One bit of a restoring integer square root.
	function automatic sqrt_t sqrt_step(input sqrt_t s);
		sqrt_t r;
		logic [REMW-1:0] rem_n;
		logic [REMW-1:0] trial;
		rem_n = {s.rem[REMW-3:0], s.rad[SW-1:SW-2]};
		trial = REMW'({s.root, 2'b01});
		r.rad = {s.rad[SW-3:0], 2'b00};
		if (rem_n >= trial) begin
			r.rem = rem_n - trial;
			r.root = {s.root[QW-2:0], 1'b1};
		end else begin
			r.rem = rem_n;
			r.root = {s.root[QW-2:0], 1'b0};
		end
		return r;
	endfunction

	// Scale by four and fold the left half plane onto the right one.
	function automatic cordic_t cordic_init(input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] x);
		cordic_t r;
		logic signed [CW-1:0] x4;
		logic signed [CW-1:0] y4;
		x4 = x <<< 2;
		y4 = y <<< 2;
		r.zero = (x == '0) && (y == '0);
		if (x[CW-1]) begin
			r.x = -x4;
			r.y = -y4;
			r.z = ANGLE_PI;
		end else begin
			r.x = x4;
			r.y = y4;
			r.z = '0;
		end
		return r;
	endfunction

	// One vectoring micro-rotation.
	function automatic cordic_t cordic_step(input cordic_t c, input int i);
		cordic_t r;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		dx = c.y >>> i;
		dy = c.x >>> i;
		r = c;
		if (!c.y[CW-1]) begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + ATAN_TAB[i];
		end else begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - ATAN_TAB[i];
		end
		return r;
	endfunction

	// Round the accumulated angle to a 16-bit binary angle.
	function automatic logic [15:0] cordic_code(input cordic_t c);
		logic [31:0] t;
		t = c.z + ROUND_HALF;
		return c.zero ? 16'h0000 : t[31:16];
	endfunction

endpackage

// File: sv/quaternion_to_euler_angles_top.sv
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on qte_pkg for widths, the arctangent table and the step functions.
// One module: matrix entries, pipelined square root and four CORDIC units.

// The block takes one unit quaternion (w, x, y, z) in signed Q1.15 per item and
// returns yaw, pitch and roll as 16-bit binary angles (32768 is pi) together with
// a near-singular flag. It is fully pipelined: a new item may enter in every clock
// cycle unless the output is held back. An item passes through 26 + CORDIC_STAGES
// registers, the first loaded at the accepting edge: six stages that register the
// samples and form the matrix entries and their sum of squares, eighteen stages
// of a one-bit-per-stage square root, one CORDIC set-up stage, CORDIC_STAGES
// micro-rotation stages run by four arctangent units side by side, and the output
// register. When the output is held back, the whole pipeline holds and in_ready
// falls; nothing is lost or repeated. The threshold register is only to be written
// while the block is empty. The input is not normalised: entries above one in
// magnitude are used as they are.
module quaternion_to_euler_angles_top import qte_pkg::*; #(
	parameter int CORDIC_STAGES = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [14:0]                   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] quat_w,
	input  logic signed [SAMPLE_BITS-1:0] quat_x,
	input  logic signed [SAMPLE_BITS-1:0] quat_y,
	input  logic signed [SAMPLE_BITS-1:0] quat_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [15:0]            yaw_angle,
	output logic signed [15:0]            pitch_angle,
	output logic signed [15:0]            roll_angle,
	output logic                          near_singular
);

	// The whole pipeline moves together whenever the output register can take
	// an item.
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// Threshold register.
	logic [14:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd1;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// Align each sample to Q1.15.
	logic signed [SAMPLE_BITS-1:0] raw [4];
	logic signed [15:0] aligned [4];
	assign raw[0] = quat_w;
	assign raw[1] = quat_x;
	assign raw[2] = quat_y;
	assign raw[3] = quat_z;

	for (genvar g = 0; g < 4; g++) begin : g_align
		if (SAMPLE_BITS > 16) begin : g_wide
			assign aligned[g] = raw[g][SAMPLE_BITS-1 -: 16];
		end else if (SAMPLE_BITS == 16) begin : g_same
			assign aligned[g] = raw[g];
		end else begin : g_narrow
			assign aligned[g] = {raw[g], {(16 - SAMPLE_BITS){1'b0}}};
		end
	end

	// Stage 1: registered samples.
	logic v_s1;
	logic signed [15:0] w_s1, x_s1, y_s1, z_s1;
	// Stage 2: the nine products.
	logic v_s2;
	logic signed [31:0] xx_s2, yy_s2, zz_s2, xy_s2, wz_s2, xz_s2, wy_s2, yz_s2, wx_s2;
	// Stage 3: matrix entries.
	logic v_s3;
	mat_t mat_s3;
	// Stage 4: m22 and m21 rounded to Q.15.
	logic v_s4;
	mat_t mat_s4;
	logic signed [RW-1:0] a_s4, b_s4;
	// Stage 5: their squares.
	logic v_s5;
	mat_t mat_s5;
	logic [SW-1:0] aa_s5, bb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	logic signed [MW-1:0] m22_rnd, m21_rnd;
	logic signed [2*RW-1:0] aa_full, bb_full;
	assign m22_rnd = mat_s3.m22 + HALF_Q15;
	assign m21_rnd = mat_s3.m21 + HALF_Q15;
	assign aa_full = a_s4 * a_s4;
	assign bb_full = b_s4 * b_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= aligned[0];
			x_s1 <= aligned[1];
			y_s1 <= aligned[2];
			z_s1 <= aligned[3];

			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			zz_s2 <= z_s1 * z_s1;
			xy_s2 <= x_s1 * y_s1;
			wz_s2 <= w_s1 * z_s1;
			xz_s2 <= x_s1 * z_s1;
			wy_s2 <= w_s1 * y_s1;
			yz_s2 <= y_s1 * z_s1;
			wx_s2 <= w_s1 * x_s1;

			mat_s3.m00 <= ONE_Q30 - ((MW'(yy_s2) + MW'(zz_s2)) <<< 1);
			mat_s3.m01 <= (MW'(xy_s2) - MW'(wz_s2)) <<< 1;
			mat_s3.m10 <= (MW'(xy_s2) + MW'(wz_s2)) <<< 1;
			mat_s3.m11 <= ONE_Q30 - ((MW'(xx_s2) + MW'(zz_s2)) <<< 1);
			mat_s3.m20 <= (MW'(xz_s2) - MW'(wy_s2)) <<< 1;
			mat_s3.m21 <= (MW'(yz_s2) + MW'(wx_s2)) <<< 1;
			mat_s3.m22 <= ONE_Q30 - ((MW'(xx_s2) + MW'(yy_s2)) <<< 1);

			mat_s4 <= mat_s3;
			a_s4 <= m22_rnd[MW-1:15];
			b_s4 <= m21_rnd[MW-1:15];

			mat_s5 <= mat_s4;
			aa_s5 <= aa_full[SW-1:0];
			bb_s5 <= bb_full[SW-1:0];
		end
	end

	// Square root: stage 6 loads the radicand, then one root bit per stage.
	logic v_sq [0:QW];
	mat_t mat_sq [0:QW];
	sqrt_t sqr_sq [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq[0] <= 1'b0;
		end else if (adv) begin
			v_sq[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mat_sq[0] <= mat_s5;
			sqr_sq[0].rad <= aa_s5 + bb_s5;
			sqr_sq[0].rem <= '0;
			sqr_sq[0].root <= '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq[k+1] <= 1'b0;
			end else if (adv) begin
				v_sq[k+1] <= v_sq[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				mat_sq[k+1] <= mat_sq[k];
				sqr_sq[k+1] <= sqrt_step(sqr_sq[k]);
			end
		end
	end

	// CORDIC set-up: index 0 holds the folded inputs of all four units.
	logic v_cd [0:CORDIC_STAGES];
	logic sing_cd [0:CORDIC_STAGES];
	logic m20_pos_cd [0:CORDIC_STAGES];
	cordic_t cd_cd [0:CORDIC_STAGES][NUM_UNITS];

	logic [QW-1:0] root;
	logic signed [CW-1:0] pitch_x, pitch_y;
	mat_t mat_c;
	assign root = sqr_sq[QW].root;
	assign mat_c = mat_sq[QW];
	assign pitch_x = CW'({root, 15'd0});
	assign pitch_y = -CW'(mat_c.m20);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_cd[0] <= 1'b0;
		end else if (adv) begin
			v_cd[0] <= v_sq[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_cd[0] <= !(root > QW'(thr_q));
			m20_pos_cd[0] <= !mat_c.m20[MW-1] && (mat_c.m20 != '0);
			cd_cd[0][U_PITCH] <= cordic_init(pitch_y, pitch_x);
			cd_cd[0][U_YAW] <= cordic_init(CW'(mat_c.m10), CW'(mat_c.m00));
			cd_cd[0][U_ROLL] <= cordic_init(CW'(mat_c.m21), CW'(mat_c.m22));
			cd_cd[0][U_ROLL_SING] <= cordic_init(-CW'(mat_c.m01), CW'(mat_c.m11));
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_cd[i+1] <= 1'b0;
			end else if (adv) begin
				v_cd[i+1] <= v_cd[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sing_cd[i+1] <= sing_cd[i];
				m20_pos_cd[i+1] <= m20_pos_cd[i];
				for (int u = 0; u < NUM_UNITS; u++) begin
					cd_cd[i+1][u] <= cordic_step(cd_cd[i][u], i);
				end
			end
		end
	end

	// Output stage: round, clamp pitch, pick the branch.
	logic [15:0] pitch_code, yaw_code, roll_code, roll_sing_code;
	logic signed [15:0] pitch_sat, roll_sel;
	logic sing_f;
	assign sing_f = sing_cd[CORDIC_STAGES];
	assign pitch_code = cordic_code(cd_cd[CORDIC_STAGES][U_PITCH]);
	assign yaw_code = cordic_code(cd_cd[CORDIC_STAGES][U_YAW]);
	assign roll_code = cordic_code(cd_cd[CORDIC_STAGES][U_ROLL]);
	assign roll_sing_code = cordic_code(cd_cd[CORDIC_STAGES][U_ROLL_SING]);

	always_comb begin
		priority if ($signed(pitch_code) > PITCH_MAX) begin
			pitch_sat = PITCH_MAX;
		end else if ($signed(pitch_code) < PITCH_MIN) begin
			pitch_sat = PITCH_MIN;
		end else begin
			pitch_sat = $signed(pitch_code);
		end
		if (!sing_f) begin
			roll_sel = $signed(roll_code);
		end else if (m20_pos_cd[CORDIC_STAGES]) begin
			roll_sel = $signed(roll_sing_code);
		end else begin
			roll_sel = $signed(16'h0000 - roll_sing_code);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_cd[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yaw_angle <= sing_f ? 16'sd0 : $signed(yaw_code);
			pitch_angle <= pitch_sat;
			roll_angle <= roll_sel;
			near_singular <= sing_f;
		end
	end

	// In the gimbal-lock branch the yaw is always reported as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && near_singular |-> yaw_angle == 16'sd0)
		else $error("yaw not zero on a near-singular item");

	// Pitch never leaves plus or minus a quarter turn.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_angle <= PITCH_MAX) && (pitch_angle >= PITCH_MIN))
		else $error("pitch outside its range");

	// An accepted item is in the first stage in the cycle after its acceptance.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item lost at pipeline entry");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the quaternion to ZYX Euler angle converter.
// Depends on quaternion_to_euler_angles_top and, through it, on qte_pkg.
// Holds an internal angle predictor, a valid/ready driver and a result monitor.
module tb_top;

	localparam int STAGES = 16;
	localparam int LATENCY = 26 + STAGES;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD = 400;

	// Arctangent of 2^-i as a 32-bit binary angle, 2^32 being a full turn.
	localparam logic [31:0] ATAN_STEP [STAGES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861
	};

	typedef struct {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct {
		logic [15:0] yaw;
		logic [15:0] pitch;
		logic [15:0] roll;
		logic        sing;
	} euler_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [14:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] yaw_angle, pitch_angle, roll_angle;
	logic near_singular;

	// Quaternions waiting to be offered, and the angles still owed by the block.
	quat_t quat_pending[$];
	euler_t angles_owed[$];
	logic [14:0] threshold;
	bit took;
	int mismatches;
	int items_in, items_out, singular_seen, idle_cycles;
	int burst_left, gap_left;
	int rx_cycle, rx_mode, hold_left;

	quaternion_to_euler_angles_top #(.CORDIC_STAGES(STAGES), .SAMPLE_BITS(16)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.yaw_angle(yaw_angle), .pitch_angle(pitch_angle), .roll_angle(roll_angle),
		.near_singular(near_singular)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Vectoring CORDIC arctangent of y/x, returned as a 16-bit binary angle.
	// The inputs are scaled by four first, and the left half plane is folded
	// onto the right one by adding a half turn.
	function automatic logic [15:0] bam_atan2(input longint y, input longint x);
		logic [31:0] ang;
		logic [31:0] rounded;
		longint dx, dy;
		ang = '0;
		x = x * 4;
		y = y * 4;
		if (x < 0) begin
			x = -x;
			y = -y;
			ang = 32'h8000_0000;
		end
		if (x == 0 && y == 0)
			return 16'h0000;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				ang = ang + ATAN_STEP[i];
			end else begin
				x = x - dx;
				y = y + dy;
				ang = ang - ATAN_STEP[i];
			end
		end
		rounded = ang + 32'h0000_8000;
		return rounded[31:16];
	endfunction

	// Floor integer square root, two bits of the radicand per step.
	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Euler angles owed for one quaternion under the current threshold.
	function automatic euler_t predict_angles(input quat_t q, input logic [14:0] thr);
		euler_t e;
		longint w, x, y, z;
		longint m00, m01, m10, m11, m20, m21, m22, a, b;
		longint unsigned c;
		logic [15:0] p;
		int ps;
		w = q.w;
		x = q.x;
		y = q.y;
		z = q.z;
		m00 = (64'sd1 <<< 30) - 2 * (y * y + z * z);
		m01 = 2 * (x * y - w * z);
		m10 = 2 * (x * y + w * z);
		m11 = (64'sd1 <<< 30) - 2 * (x * x + z * z);
		m20 = 2 * (x * z - w * y);
		m21 = 2 * (y * z + w * x);
		m22 = (64'sd1 <<< 30) - 2 * (x * x + y * y);
		// The root is taken of the two entries rounded to 15 fraction bits.
		a = (m22 + 16384) >>> 15;
		b = (m21 + 16384) >>> 15;
		c = floor_sqrt(longint'(a * a + b * b));
		p = bam_atan2(-m20, longint'(c) * 32768);
		ps = int'(signed'(p));
		if (ps > 16384)
			ps = 16384;
		if (ps < -16384)
			ps = -16384;
		e.pitch = ps[15:0];
		if (c > longint'(thr)) begin
			e.sing = 1'b0;
			e.yaw = bam_atan2(m10, m00);
			e.roll = bam_atan2(m21, m22);
		end else begin
			// Gimbal lock: yaw is pinned to zero and roll takes the sign of m20.
			e.sing = 1'b1;
			e.yaw = 16'h0000;
			e.roll = bam_atan2(-m01, m11);
			if (!(m20 > 0))
				e.roll = 16'h0000 - e.roll;
		end
		return e;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatches++;
		$display("mismatch on result %0d: %s got %0d expected %0d", items_out, what,
			$signed(got), $signed(want));
	endtask

	// Acceptance on the input side feeds the predictor; the monitor checks each
	// accepted result against the oldest owed set of angles. The watchdog also
	// lives here, counting cycles in which neither side moves an item.
	always @(posedge clk) begin
		euler_t e;
		took = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				angles_owed = {angles_owed, predict_angles(quat_pending[0], threshold)};
				void'(quat_pending.pop_front());
				items_in++;
				took = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (angles_owed.size() == 0) begin
					report_mismatch("unexpected result, yaw", yaw_angle, 16'h0000);
				end else begin
					e = angles_owed.pop_front();
					if (yaw_angle !== e.yaw)
						report_mismatch("yaw", yaw_angle, e.yaw);
					if (pitch_angle !== e.pitch)
						report_mismatch("pitch", pitch_angle, e.pitch);
					if (roll_angle !== e.roll)
						report_mismatch("roll", roll_angle, e.roll);
					if (near_singular !== e.sing)
						report_mismatch("near_singular", 16'(near_singular), 16'(e.sing));
					singular_seen += e.sing;
				end
				items_out++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Driver: bursts of random length separated by random gaps. A held item
	// keeps its payload until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (quat_pending.size() > 0) begin
				in_valid <= 1'b1;
				quat_w <= quat_pending[0].w;
				quat_x <= quat_pending[0].x;
				quat_y <= quat_pending[0].y;
				quat_z <= quat_pending[0].z;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: its mode is redrawn periodically among always ready, mostly ready
	// and mostly stalled. Once in the run it holds off for a long stretch so that
	// the pipeline fills and the input side is pushed back.
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle % 100 == 0)
				rx_mode = $urandom_range(0, 2);
			if (rx_cycle == 1000)
				hold_left = LONG_HOLD;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic add_quat(input int w, input int x, input int y, input int z);
		quat_t q;
		q.w = 16'(w);
		q.x = 16'(x);
		q.y = 16'(y);
		q.z = 16'(z);
		quat_pending = {quat_pending, q};
	endtask

	function automatic int clip(input real v);
		int r;
		r = $rtoi(v);
		return (r > 32767) ? 32767 : (r < -32768) ? -32768 : r;
	endfunction

	// Scales a direction to unit length in Q1.15, clipped to the code range.
	task automatic add_unit(input real w, input real x, input real y, input real z);
		real n;
		n = $sqrt(w * w + x * x + y * y + z * z);
		if (n < 1.0)
			n = 1.0;
		add_quat(clip(w * 32767.0 / n), clip(x * 32767.0 / n),
			clip(y * 32767.0 / n), clip(z * 32767.0 / n));
	endtask

	function automatic real rnd_comp(input int span);
		return real'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic wait_drained();
		while (quat_pending.size() > 0 || angles_owed.size() > 0)
			@(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [14:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		threshold = v;
	endtask

	// Random quaternions: mostly unit length, a share close to gimbal lock,
	// and some raw codes that cover every bit and unnormalised input.
	task automatic add_random(input int count);
		int kind;
		real s;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				add_unit(rnd_comp(32768), rnd_comp(32768), rnd_comp(32768), rnd_comp(32768));
			end else if (kind < 8) begin
				// w and y of equal size put pitch near a quarter turn.
				s = ($urandom_range(0, 1) != 0) ? 1.0 : -1.0;
				add_unit(23170.0 + rnd_comp(60), rnd_comp(40), s * 23170.0 + rnd_comp(60),
					rnd_comp(40));
			end else begin
				add_quat(int'($urandom_range(0, 65535)) - 32768,
					int'($urandom_range(0, 65535)) - 32768,
					int'($urandom_range(0, 65535)) - 32768,
					int'($urandom_range(0, 65535)) - 32768);
			end
		end
	endtask

	initial begin
		logic [14:0] thr_plan [5];
		thr_plan = '{15'd0, 15'd32767, 15'd200, 15'd3000, 15'd16384};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		quat_w = '0;
		quat_x = '0;
		quat_y = '0;
		quat_z = '0;
		threshold = 15'd1;
		took = 1'b0;
		mismatches = 0;
		items_in = 0;
		items_out = 0;
		singular_seen = 0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		rx_cycle = 0;
		rx_mode = 0;
		hold_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items under the reset threshold: identity, the code
		// extremes, the zero vector, half turns that wrap to -32768, both
		// gimbal-lock poles and unnormalised input well above unit length.
		add_quat(32767, 0, 0, 0);
		add_quat(-32768, 0, 0, 0);
		add_quat(0, 0, 0, 0);
		add_quat(0, 32767, 0, 0);
		add_quat(0, -32768, 0, 0);
		add_quat(0, 0, 32767, 0);
		add_quat(0, 0, 0, 32767);
		add_quat(0, 0, 0, -32768);
		add_quat(32767, 32767, 32767, 32767);
		add_quat(-32768, -32768, -32768, -32768);
		add_quat(32767, -32768, 32767, -32768);
		add_quat(23170, 0, 23170, 0);
		add_quat(23170, 0, -23170, 0);
		add_quat(-23170, 0, 23170, 0);
		add_quat(23170, 5000, 23170, -5000);
		add_quat(16384, 16384, 16384, -16384);
		add_quat(0, 23170, 0, 23170);
		add_quat(1, 0, 0, 0);
		add_quat(-1, -1, -1, -1);
		add_quat(30000, 20000, -25000, 10000);
		add_random(250);
		wait_drained();

		foreach (thr_plan[k]) begin
			write_threshold(thr_plan[k]);
			add_quat(23170, 0, 23170, 0);
			add_quat(23170, 0, -23170, 0);
			add_random(250);
			wait_drained();
		end
		// Back to the reset value for a final check of the write path.
		write_threshold(15'd1);
		add_random(20);
		wait_drained();

		$display("covered %0d quaternions and %0d results, %0d of them near gimbal lock,",
			items_in, items_out, singular_seen);
		$display("under six threshold settings from 0 to 32767 with random stalls on both sides");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
sv/qte_pkg.sv
sv/quaternion_to_euler_angles_top.sv
sim/tb_top.sv
